[sv/sspi_pkg.sv]
// Shared types and constants of the sorted slope index range query unit.
// Depends on nothing; every file but sspi_ram imports it.
`default_nettype none
package sspi_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_MATCH    = 2'd2;
  localparam logic [1:0] ST_NO_MATCH = 2'd3;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef struct packed {
    logic [15:0]        key;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic [7:0]         pts;
    logic signed [19:0] fz;
    logic signed [19:0] lz;
    logic [31:0]        id;
  } entry_t;

  localparam int EW = $bits(entry_t);

  typedef struct packed {
    logic load;
    logic sq_x;
    logic sq_y;
    logic sq_step;
    logic idx_init;
    logic shift_wr;
    logic new_wr;
    logic emit_full;
    logic dx_sq;
    logic dy_sq;
    logic take;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic full;
    logic sq_last;
    logic idx_neg;
    logic scan_done;
    logic key_ge;
  } sts_t;

endpackage
`default_nettype wire

[sv/sspi_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module sspi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[sv/sspi_ctrl.sv]
// Sequencer of the sorted slope index unit: issues datapath commands.
// Depends on sspi_pkg.
`default_nettype none
module sspi_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire sspi_pkg::sts_t sts,
  output sspi_pkg::cmd_t     cmd
);
  import sspi_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_SQX   = 13'b0000000000010,
    S_SQY   = 13'b0000000000100,
    S_SQRT  = 13'b0000000001000,
    S_I_RD  = 13'b0000000010000,
    S_I_CHK = 13'b0000000100000,
    S_I_NEW = 13'b0000001000000,
    S_FULL  = 13'b0000010000000,
    S_Q_RD  = 13'b0000100000000,
    S_Q_DX  = 13'b0001000000000,
    S_Q_DY  = 13'b0010000000000,
    S_Q_TK  = 13'b0100000000000,
    S_Q_FIN = 13'b1000000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_SQX;
        end
      end
      S_SQX: begin
        cmd.sq_x = 1'b1;
        state_next = S_SQY;
      end
      S_SQY: begin
        cmd.sq_y = 1'b1;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.sq_step = 1'b1;
        if (sts.sq_last) begin
          cmd.idx_init = 1'b1;
          if (sts.is_query) begin
            state_next = S_Q_RD;
          end else if (sts.full) begin
            state_next = S_FULL;
          end else begin
            state_next = S_I_RD;
          end
        end
      end
      S_I_RD: begin
        state_next = sts.idx_neg ? S_I_NEW : S_I_CHK;
      end
      S_I_CHK: begin
        if (sts.key_ge) begin
          cmd.shift_wr = 1'b1;
          state_next = S_I_RD;
        end else begin
          state_next = S_I_NEW;
        end
      end
      S_I_NEW: begin
        cmd.new_wr = 1'b1;
        state_next = S_IDLE;
      end
      S_FULL: begin
        cmd.emit_full = 1'b1;
        state_next = S_IDLE;
      end
      S_Q_RD: begin
        state_next = sts.scan_done ? S_Q_FIN : S_Q_DX;
      end
      S_Q_DX: begin
        cmd.dx_sq = 1'b1;
        state_next = S_Q_DY;
      end
      S_Q_DY: begin
        cmd.dy_sq = 1'b1;
        state_next = S_Q_TK;
      end
      S_Q_TK: begin
        cmd.take = 1'b1;
        state_next = S_Q_RD;
      end
      S_Q_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

[sv/sspi_dp.sv]
// Datapath: operand registers, square root, table RAM, filters, result word.
// Depends on sspi_pkg and sspi_ram.
`default_nettype none
module sspi_dp (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sspi_pkg::cmd_t     cmd,
  output sspi_pkg::sts_t          sts,
  input  wire logic               cfg_write,
  input  wire logic signed [19:0] cfg_data,
  input  wire logic               op,
  input  wire logic signed [15:0] slope_x,
  input  wire logic signed [15:0] slope_y,
  input  wire logic [7:0]         point_count,
  input  wire logic signed [19:0] first_z,
  input  wire logic signed [19:0] last_z,
  input  wire logic [31:0]        track_id,
  input  wire logic [15:0]        radius,
  input  wire logic               isotropic,
  input  wire logic [7:0]         min_points,
  input  wire logic signed [19:0] z_top,
  input  wire logic signed [19:0] z_bottom,
  output logic                    result_valid,
  output logic [1:0]              status,
  output logic [5:0]              position,
  output logic [31:0]             stored_id,
  output logic                    last
);
  import sspi_pkg::*;

  logic signed [19:0] zref;
  logic [CW-1:0]      cnt;
  logic [CW-1:0]      idx;
  logic               op_q, iso_q;
  logic signed [15:0] sx_q, sy_q;
  logic [7:0]         pts_q, minp_q;
  logic signed [19:0] fz_q, lz_q, ztop_q, zbot_q;
  logic [31:0]        id_q;
  logic [15:0]        r_q;
  logic [31:0]        r2;
  logic [31:0]        sqn;
  logic [17:0]        rem;
  logic [15:0]        root;
  logic [3:0]         sq_cnt;
  logic [33:0]        prod;
  logic [33:0]        dist_sq;
  logic               pass_f;
  logic               pend_valid;
  logic [AW-1:0]      pend_pos;
  logic [31:0]        pend_id;

  entry_t             rdata, wdata, new_e;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [CW-1:0]      idx_up;

  logic [17:0]        rem_sh, trial;
  logic signed [16:0] dx, dy;
  logic [16:0]        lo_sum, hi_sum;
  logic               match;

  function automatic logic signed [19:0] zsat(input logic signed [20:0] v);
    logic signed [20:0] zmax, zmin;
    zmax = 21'sd524287;
    zmin = -21'sd524288;
    if (v > zmax) begin
      return 20'sd524287;
    end else if (v < zmin) begin
      return -20'sd524288;
    end
    return v[19:0];
  endfunction

  assign idx_up = idx + CW'(1);
  assign we     = cmd.shift_wr | cmd.new_wr;
  assign waddr  = idx_up[AW-1:0];

  always_comb begin
    new_e.key = root;
    new_e.sx  = sx_q;
    new_e.sy  = sy_q;
    new_e.pts = pts_q;
    new_e.fz  = fz_q;
    new_e.lz  = lz_q;
    new_e.id  = id_q;
    wdata = cmd.new_wr ? new_e : rdata;
  end

  sspi_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx[AW-1:0]),
    .rdata (rdata)
  );

  // one square-root digit per step
  assign rem_sh = {rem[15:0], sqn[31:30]};
  assign trial  = {root, 2'b01};

  assign dx = 17'(rdata.sx) - 17'(sx_q);
  assign dy = 17'(rdata.sy) - 17'(sy_q);
  assign lo_sum = 17'(rdata.key) + 17'(r_q);
  assign hi_sum = 17'(root) + 17'(r_q);
  assign match = pass_f && (iso_q || (dist_sq <= 34'(r2)));

  always_comb begin
    sts.is_query  = (op_q == OP_QUERY);
    sts.full      = (cnt == CW'(TABLE_DEPTH));
    sts.sq_last   = (sq_cnt == 4'd15);
    sts.idx_neg   = (idx == '1);
    sts.scan_done = (idx == cnt);
    sts.key_ge    = (rdata.key >= root);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zref <= '0;
      cnt <= '0;
      result_valid <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_write) begin
        zref <= cfg_data;
      end
      if (cmd.load) begin
        pend_valid <= 1'b0;
      end
      if (cmd.new_wr) begin
        cnt <= cnt + CW'(1);
        result_valid <= 1'b1;
      end
      if (cmd.emit_full) begin
        result_valid <= 1'b1;
      end
      if (cmd.take && match) begin
        pend_valid <= 1'b1;
        result_valid <= pend_valid;
      end
      if (cmd.finish) begin
        result_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= op;
      iso_q  <= isotropic;
      sx_q   <= slope_x;
      sy_q   <= slope_y;
      pts_q  <= point_count;
      minp_q <= min_points;
      fz_q   <= zsat(21'(first_z) - 21'(zref));
      lz_q   <= zsat(21'(last_z) - 21'(zref));
      ztop_q <= z_top;
      zbot_q <= z_bottom;
      id_q   <= track_id;
      r_q    <= radius;
    end
    if (cmd.sq_x) begin
      sqn    <= 32'(sx_q * sx_q);
      r2     <= 32'(r_q) * 32'(r_q);
      rem    <= '0;
      root   <= '0;
      sq_cnt <= '0;
    end
    if (cmd.sq_y) begin
      sqn <= sqn + 32'(sy_q * sy_q);
    end
    if (cmd.sq_step) begin
      sqn    <= {sqn[29:0], 2'b00};
      sq_cnt <= sq_cnt + 4'd1;
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[14:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[14:0], 1'b0};
      end
    end
    if (cmd.idx_init) begin
      idx <= (op_q == OP_QUERY) ? '0 : cnt - CW'(1);
    end
    if (cmd.shift_wr) begin
      idx <= idx - CW'(1);
    end
    if (cmd.new_wr) begin
      status    <= ST_INSERTED;
      position  <= 6'(idx_up);
      stored_id <= id_q;
      last      <= 1'b1;
    end
    if (cmd.emit_full) begin
      status    <= ST_FULL;
      position  <= '0;
      stored_id <= id_q;
      last      <= 1'b1;
    end
    if (cmd.dx_sq) begin
      prod   <= 34'(dx * dx);
      pass_f <= (lo_sum >= 17'(root)) && (17'(rdata.key) <= hi_sum) &&
                (rdata.pts >= minp_q) && (rdata.fz >= ztop_q) && (rdata.lz <= zbot_q);
    end
    if (cmd.dy_sq) begin
      dist_sq <= prod + 34'(dy * dy);
    end
    if (cmd.take) begin
      idx <= idx + CW'(1);
      if (match) begin
        pend_pos  <= idx[AW-1:0];
        pend_id   <= rdata.id;
        status    <= ST_MATCH;
        position  <= 6'(pend_pos);
        stored_id <= pend_id;
        last      <= 1'b0;
      end
    end
    if (cmd.finish) begin
      status    <= pend_valid ? ST_MATCH : ST_NO_MATCH;
      position  <= pend_valid ? 6'(pend_pos) : 6'd0;
      stored_id <= pend_valid ? pend_id : 32'd0;
      last      <= 1'b1;
    end
  end
endmodule
`default_nettype wire

[sv/sorted_slope_index_range_query_unit.sv]
// Top level of the sorted slope index range query unit.
// Depends on sspi_pkg, sspi_ctrl and sspi_dp (which holds sspi_ram).
//
// A table of up to 64 tracks kept in ascending order of slope magnitude,
// floor(sqrt(sx^2+sy^2)) in unsigned Q16.0. Raise start with an
// input word while busy is low; busy then stays high until the cycle that
// shows the item's final result word, and drops in that cycle.
// Each result word shows for exactly one cycle with result_valid high, and
// the receiver cannot stall it. An insert gives one word (inserted or table
// full); a query gives one word per match in table order, the final one with
// last set, or a single no-match word. Each item loads its operands, squares
// and sums the slope components and takes sixteen root digits; an insert then
// moves each entry whose key is not below the new one up a slot, top down, as
// the table RAM has one read and one write port, and writes the new entry; a
// query visits every stored entry through the same read port. Write z_reference
// through cfg_write/cfg_data only while busy is low; the block itself does
// not enforce this.
`default_nettype none
module sorted_slope_index_range_query_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               cfg_write,
  input  wire logic signed [19:0] cfg_data,
  input  wire logic               op,
  input  wire logic signed [15:0] slope_x,
  input  wire logic signed [15:0] slope_y,
  input  wire logic [7:0]         point_count,
  input  wire logic signed [19:0] first_z,
  input  wire logic signed [19:0] last_z,
  input  wire logic [31:0]        track_id,
  input  wire logic [15:0]        radius,
  input  wire logic               isotropic,
  input  wire logic [7:0]         min_points,
  input  wire logic signed [19:0] z_top,
  input  wire logic signed [19:0] z_bottom,
  output logic                    result_valid,
  output logic [1:0]              status,
  output logic [5:0]              position,
  output logic [31:0]             stored_id,
  output logic                    last
);
  import sspi_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: one item at a time
  sspi_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // datapath: hold operands, compute magnitude, walk the table
  sspi_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .op           (op),
    .slope_x      (slope_x),
    .slope_y      (slope_y),
    .point_count  (point_count),
    .first_z      (first_z),
    .last_z       (last_z),
    .track_id     (track_id),
    .radius       (radius),
    .isotropic    (isotropic),
    .min_points   (min_points),
    .z_top        (z_top),
    .z_bottom     (z_bottom),
    .result_valid (result_valid),
    .status       (status),
    .position     (position),
    .stored_id    (stored_id),
    .last         (last)
  );
endmodule
`default_nettype wire

[verif/tb_sorted_slope_index_range_query_unit.sv]
// Testbench of the sorted slope index range query unit: directed and random
// inserts and range queries, results checked against an in-bench predictor.
// Depends on sspi_pkg and sorted_slope_index_range_query_unit.
`default_nettype none
module tb_sorted_slope_index_range_query_unit;
  import sspi_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  position;
    logic [31:0] stored_id;
    logic        last;
  } answer_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               cfg_write = 1'b0;
  logic signed [19:0] cfg_data = '0;
  logic               op = OP_INSERT;
  logic signed [15:0] slope_x = '0;
  logic signed [15:0] slope_y = '0;
  logic [7:0]         point_count = '0;
  logic signed [19:0] first_z = '0;
  logic signed [19:0] last_z = '0;
  logic [31:0]        track_id = '0;
  logic [15:0]        radius = '0;
  logic               isotropic = 1'b0;
  logic [7:0]         min_points = '0;
  logic signed [19:0] z_top = '0;
  logic signed [19:0] z_bottom = '0;
  logic               result_valid;
  logic [1:0]         status;
  logic [5:0]         position;
  logic [31:0]        stored_id;
  logic               last;

  sorted_slope_index_range_query_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .op(op), .slope_x(slope_x), .slope_y(slope_y), .point_count(point_count),
    .first_z(first_z), .last_z(last_z), .track_id(track_id), .radius(radius),
    .isotropic(isotropic), .min_points(min_points), .z_top(z_top),
    .z_bottom(z_bottom), .result_valid(result_valid), .status(status),
    .position(position), .stored_id(stored_id), .last(last)
  );

  always #4 clk = ~clk;

  // Shadow copy of the track table, kept in slope-magnitude order.
  int unsigned        track_count;
  logic [15:0]        shadow_key [TABLE_DEPTH];
  logic signed [15:0] shadow_sx  [TABLE_DEPTH];
  logic signed [15:0] shadow_sy  [TABLE_DEPTH];
  logic [7:0]         shadow_pts [TABLE_DEPTH];
  logic signed [19:0] shadow_fz  [TABLE_DEPTH];
  logic signed [19:0] shadow_lz  [TABLE_DEPTH];
  logic [31:0]        shadow_id  [TABLE_DEPTH];
  logic signed [19:0] shadow_zref;

  answer_t pending_answers[$];
  int      mismatches;

  // Exact integer root of sx^2 + sy^2, digit by digit.
  function automatic logic [15:0] slope_magnitude(logic signed [15:0] sx,
                                                   logic signed [15:0] sy);
    longint unsigned rem, root, bitv;
    rem  = longint'(sx) * longint'(sx) + longint'(sy) * longint'(sy);
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  -= root + bitv;
        root  = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root[15:0];
  endfunction

  function automatic logic signed [19:0] clamp_z(longint v);
    if (v > 524287) return 20'sd524287;
    if (v < -524288) return -20'sd524288;
    return v[19:0];
  endfunction

  // Predict the result words of one item and update the shadow table.
  task automatic predict_table_op();
    logic [15:0] qkey;
    longint      lo, hi, dx, dy;
    longint unsigned r2;
    int          slot, hits;
    answer_t     a;
    qkey = slope_magnitude(slope_x, slope_y);
    if (op == OP_INSERT) begin
      if (track_count >= TABLE_DEPTH) begin
        a = '{ST_FULL, 6'd0, track_id, 1'b1};
        pending_answers.push_back(a);
        return;
      end
      slot = 0;
      while (slot < track_count && shadow_key[slot] < qkey) slot++;
      for (int i = track_count; i > slot; i--) begin
        shadow_key[i] = shadow_key[i-1]; shadow_sx[i] = shadow_sx[i-1];
        shadow_sy[i] = shadow_sy[i-1];   shadow_pts[i] = shadow_pts[i-1];
        shadow_fz[i] = shadow_fz[i-1];   shadow_lz[i] = shadow_lz[i-1];
        shadow_id[i] = shadow_id[i-1];
      end
      shadow_key[slot] = qkey;  shadow_sx[slot] = slope_x;
      shadow_sy[slot] = slope_y; shadow_pts[slot] = point_count;
      shadow_fz[slot] = clamp_z(longint'(first_z) - longint'(shadow_zref));
      shadow_lz[slot] = clamp_z(longint'(last_z) - longint'(shadow_zref));
      shadow_id[slot] = track_id;
      track_count++;
      a = '{ST_INSERTED, 6'(slot), track_id, 1'b1};
      pending_answers.push_back(a);
    end else begin
      lo   = longint'(qkey) - longint'(radius);
      hi   = longint'(qkey) + longint'(radius);
      r2   = longint'(radius) * longint'(radius);
      hits = 0;
      for (int i = 0; i < track_count; i++) begin
        if (longint'(shadow_key[i]) < lo || longint'(shadow_key[i]) > hi) continue;
        if (shadow_pts[i] < min_points) continue;
        if (shadow_fz[i] < z_top || shadow_lz[i] > z_bottom) continue;
        if (!isotropic) begin
          dx = longint'(shadow_sx[i]) - longint'(slope_x);
          dy = longint'(shadow_sy[i]) - longint'(slope_y);
          if (longint'(dx * dx + dy * dy) > longint'(r2)) continue;
        end
        a = '{ST_MATCH, 6'(i), shadow_id[i], 1'b0};
        pending_answers.push_back(a);
        hits++;
      end
      if (hits == 0) begin
        a = '{ST_NO_MATCH, 6'd0, 32'd0, 1'b1};
        pending_answers.push_back(a);
      end else begin
        pending_answers[pending_answers.size()-1].last = 1'b1;
      end
    end
  endtask

  // Hold the word on the ports until it is taken, then predict it.
  task automatic send_word(logic o, logic signed [15:0] sx, logic signed [15:0] sy,
                           logic [7:0] pts, logic signed [19:0] fz, logic signed [19:0] lz,
                           logic [31:0] id, logic [15:0] rad, logic iso, logic [7:0] minp,
                           logic signed [19:0] zt, logic signed [19:0] zb,
                           bit pace = 1'b1);
    int gap;
    gap = pace ? $urandom_range(0, 15) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;  // leave back-to-back stretches
    repeat (gap) @(posedge clk);
    op <= o; slope_x <= sx; slope_y <= sy; point_count <= pts;
    first_z <= fz; last_z <= lz; track_id <= id; radius <= rad;
    isotropic <= iso; min_points <= minp; z_top <= zt; z_bottom <= zb;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    predict_table_op();
    start <= 1'b0;
    @(posedge clk);  // busy rises on the edge after acceptance
  endtask

  // Drain outstanding words, allow for the block's tail, then rewrite z_reference.
  task automatic settle_and_set_zref(logic signed [19:0] value);
    int guard;
    guard = 0;
    while ((pending_answers.size() != 0 || busy) && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    shadow_zref = value;
  endtask

  function automatic logic signed [15:0] rand_slope();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'(int'($urandom_range(0, 200)) - 100);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic insert_random();
    send_word(OP_INSERT, rand_slope(), rand_slope(), 8'($urandom),
              20'($urandom), 20'($urandom), $urandom, 16'($urandom),
              1'($urandom), 8'($urandom), 20'($urandom), 20'($urandom));
  endtask

  // Mostly wide-open windows so that matches come through.
  task automatic query_random();
    logic [15:0] rad;
    logic [7:0]  minp;
    logic signed [19:0] zt, zb;
    rad  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16383));
    minp = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40));
    zt   = ($urandom_range(0, 2) == 0) ? 20'($urandom) : -20'sd524288;
    zb   = ($urandom_range(0, 2) == 0) ? 20'($urandom) : 20'sd524287;
    send_word(OP_QUERY, rand_slope(), rand_slope(), 8'($urandom), 20'($urandom),
              20'($urandom), $urandom, rad, 1'($urandom), minp, zt, zb);
  endtask

  // Field extremes, both ops, query on an empty table, window below zero.
  task automatic test_directed_extremes();
    send_word(OP_QUERY, 16'sd0, 16'sd0, 8'd0, 20'sd0, 20'sd0, 32'd0, 16'hFFFF, 1'b1,
              8'd0, -20'sd524288, 20'sd524287);
    send_word(OP_INSERT, 16'sh8000, 16'sh8000, 8'hFF, 20'sd524287, -20'sd524288,
              32'hFFFF_FFFF, 16'h0, 1'b0, 8'h0, 20'sd0, 20'sd0);
    send_word(OP_INSERT, 16'sd0, 16'sd0, 8'd0, -20'sd524288, 20'sd524287,
              32'h0, 16'hFFFF, 1'b1, 8'hFF, 20'sd0, 20'sd0);
    send_word(OP_INSERT, 16'sh7FFF, 16'sd0, 8'd10, 20'sd5, 20'sd9,
              32'hA5A5_0001, 16'h0, 1'b0, 8'h0, 20'sd0, 20'sd0);
    send_word(OP_INSERT, 16'sd0, 16'sh7FFF, 8'd10, 20'sd5, 20'sd9,
              32'h5A5A_0002, 16'h0, 1'b0, 8'h0, 20'sd0, 20'sd0);
    send_word(OP_INSERT, 16'sd3, 16'sd4, 8'd20, 20'sd0, 20'sd0,
              32'h0000_0005, 16'h0, 1'b0, 8'h0, 20'sd0, 20'sd0);
    // Isotropic wide query, anisotropic with zero radius, small window below zero.
    send_word(OP_QUERY, 16'sd3, 16'sd4, 8'd0, 20'sd0, 20'sd0, 32'd0, 16'hFFFF, 1'b1,
              8'd0, -20'sd524288, 20'sd524287);
    send_word(OP_QUERY, 16'sh7FFF, 16'sd0, 8'd0, 20'sd0, 20'sd0, 32'd0, 16'd0, 1'b0,
              8'd0, -20'sd524288, 20'sd524287);
    send_word(OP_QUERY, 16'sd1, 16'sd0, 8'd0, 20'sd0, 20'sd0, 32'd0, 16'd10, 1'b0,
              8'd0, -20'sd524288, 20'sd524287);
    send_word(OP_QUERY, 16'sh8000, 16'sh8000, 8'd0, 20'sd0, 20'sd0, 32'd0, 16'hFFFF,
              1'b0, 8'hFF, 20'sd524287, -20'sd524288);
    send_word(OP_QUERY, 16'sd0, 16'sh7FFF, 8'd0, 20'sd0, 20'sd0, 32'd0, 16'd100, 1'b1,
              8'd15, 20'sd5, 20'sd9);
  endtask

  // Push z offsets past both saturation limits.
  task automatic test_z_saturation();
    settle_and_set_zref(20'sd524287);
    send_word(OP_INSERT, 16'sd100, 16'sd0, 8'd1, -20'sd524288, 20'sd524287,
              32'hC0DE_0001, 16'h0, 1'b0, 8'h0, 20'sd0, 20'sd0);
    settle_and_set_zref(-20'sd524288);
    send_word(OP_INSERT, 16'sd100, 16'sd1, 8'd1, 20'sd524287, -20'sd524288,
              32'hC0DE_0002, 16'h0, 1'b0, 8'h0, 20'sd0, 20'sd0);
    send_word(OP_QUERY, 16'sd100, 16'sd0, 8'd0, 20'sd0, 20'sd0, 32'd0, 16'd4, 1'b1,
              8'd0, -20'sd524288, 20'sd524287);
  endtask

  // Random mix that fills the table, then runs the full path.
  task automatic test_random_mix();
    for (int n = 0; n < 170; n++) begin
      if (n % 50 == 49) settle_and_set_zref(20'($urandom));
      if (track_count < TABLE_DEPTH && $urandom_range(0, 1) == 0) insert_random();
      else if ($urandom_range(0, 9) == 0) insert_random();
      else query_random();
    end
  endtask

  // Checker: every strobed word against the oldest expectation.
  always @(posedge clk) begin
    answer_t want;
    if (!rst && result_valid) begin
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: status %0d position %0d id %h last %0b",
                   status, position, stored_id, last);
      end else begin
        want = pending_answers.pop_front();
        if (status !== want.status || position !== want.position ||
            stored_id !== want.stored_id || last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want %0d/%0d/%h/%0b got %0d/%0d/%h/%0b",
                     want.status, want.position, want.stored_id, want.last,
                     status, position, stored_id, last);
        end
      end
    end
  end

  initial begin
    int guard;
    mismatches  = 0;
    track_count = 0;
    shadow_zref = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_extremes();
    test_z_saturation();
    settle_and_set_zref(20'sd0);
    test_random_mix();
    guard = 0;
    while ((pending_answers.size() != 0 || busy) && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_answers.size() == 0)
      $display("PASS sorted_slope_index_range_query_unit");
    else
      $display("FAIL sorted_slope_index_range_query_unit");
    $finish;
  end

  // Watchdog: well above the slowest legal run.
  initial begin
    #8000000;
    $display("FAIL sorted_slope_index_range_query_unit");
    $finish;
  end
endmodule
`default_nettype wire
